### hdl/sfc_pkg.sv
`default_nettype none
package sfc_pkg;

  // commands from the sequencer to the byte window
  typedef struct packed {
    logic push;
    logic clear;
  } win_cmd_t;

  // commands from the sequencer to the fragment table
  typedef struct packed {
    logic count;
    logic read;
    logic clear;
  } tbl_cmd_t;

  // table status back to the sequencer
  typedef struct packed {
    logic busy;
    logic rd_ok;
    logic overflow;
  } tbl_stat_t;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

endpackage
`default_nettype wire

### hdl/sfc_window.sv
`default_nettype none
module sfc_window #(
  parameter int MAX_BYTES = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  sfc_pkg::win_cmd_t  cmd,
  input  wire  [7:0]         text_byte,
  input  wire  [3:0]         frag_len,
  input  wire  [7:0]         stride,
  output logic               busy,
  output logic               pend_valid,
  output logic [63:0]        pend_key
);
  import sfc_pkg::*;

  localparam int SW = $clog2(MAX_BYTES + 1);
  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_DIV  = 2'd1;
  localparam logic [1:0] W_FIN  = 2'd2;

  logic [1:0]    wstate;
  logic [63:0]   window;
  logic [SW-1:0] bytes_seen;
  logic [7:0]    phase;
  logic [7:0]    new_byte;
  logic [7:0]    rem;
  logic [7:0]    dvd;
  logic [2:0]    step;
  logic [7:0]    len_mod;

  logic [3:0]  len_eff;
  logic [7:0]  g_eff;
  logic [8:0]  div_t;
  logic [7:0]  rem_next;
  logic [8:0]  pos_inc;
  logic [7:0]  pos_next;
  logic [63:0] window_next;
  logic [4:0]  seen_inc;
  logic        ends_here;
  logic [5:0]  key_shift;

  always_comb begin
    len_eff = (frag_len == 4'd0) ? 4'd1 : frag_len;
    if (len_eff > 4'(MAX_BYTES)) len_eff = 4'(MAX_BYTES);
    g_eff = (stride == 8'd0) ? 8'd1 : stride;
  end

  // one restoring step of phase % stride
  always_comb begin
    div_t = {rem, dvd[7]};
    if (div_t >= {1'b0, g_eff}) rem_next = 8'(div_t - {1'b0, g_eff});
    else rem_next = div_t[7:0];
  end

  always_comb begin
    pos_inc     = {1'b0, rem} + 9'd1;
    pos_next    = (pos_inc == {1'b0, g_eff}) ? 8'd0 : pos_inc[7:0];
    window_next = {new_byte, window[63:8]};
    seen_inc    = {1'b0, 4'(bytes_seen)} + 5'd1;
    ends_here   = (seen_inc >= {1'b0, len_eff}) && (pos_next == len_mod);
    key_shift   = {3'(4'd8 - len_eff), 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wstate     <= W_IDLE;
      window     <= '0;
      bytes_seen <= '0;
      phase      <= '0;
      pend_valid <= 1'b0;
      pend_key   <= '0;
    end else begin
      case (wstate)
        W_IDLE: begin
          if (cmd.clear) begin
            window     <= '0;
            bytes_seen <= '0;
            phase      <= '0;
            pend_valid <= 1'b0;
            pend_key   <= '0;
          end else if (cmd.push) begin
            wstate <= W_DIV;
          end
        end
        W_DIV: begin
          if (step == 3'd7) wstate <= W_FIN;
        end
        W_FIN: begin
          window     <= window_next;
          pend_valid <= ends_here;
          if (ends_here) pend_key <= window_next >> key_shift;
          if (bytes_seen < SW'(MAX_BYTES)) bytes_seen <= bytes_seen + SW'(1);
          phase  <= pos_next;
          wstate <= W_IDLE;
        end
        default: wstate <= W_IDLE;
      endcase
    end
  end

  // length is at most 8, so one conditional subtract per division step
  // finishes len % stride along with the phase remainder
  always_ff @(posedge clk) begin
    if (wstate == W_IDLE && cmd.push) begin
      new_byte <= text_byte;
      rem      <= '0;
      dvd      <= phase;
      step     <= '0;
      len_mod  <= {4'd0, len_eff};
    end else if (wstate == W_DIV) begin
      rem  <= rem_next;
      dvd  <= {dvd[6:0], 1'b0};
      step <= step + 3'd1;
      if (len_mod >= g_eff) len_mod <= len_mod - g_eff;
    end
  end

  assign busy = (wstate != W_IDLE);

endmodule
`default_nettype wire

### hdl/sfc_table.sv
`default_nettype none
module sfc_table #(
  parameter int DEPTH = 256
) (
  input  wire                          clk,
  input  wire                          rst,
  input  sfc_pkg::tbl_cmd_t            cmd,
  input  wire  [63:0]                  key_in,
  input  wire  [7:0]                   entry_index,
  output sfc_pkg::tbl_stat_t           stat,
  output logic [63:0]                  rd_key,
  output logic [23:0]                  rd_count,
  output logic [$clog2(DEPTH+1)-1:0]   used
);
  import sfc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int UW = $clog2(DEPTH + 1);
  localparam int CW = UW + 8;
  localparam logic T_IDLE = 1'b0;
  localparam logic T_SCAN = 1'b1;

  logic [63:0] key_mem [DEPTH];
  logic [23:0] count_mem [DEPTH];

  logic          tstate;
  logic [63:0]   key;
  logic [UW-1:0] addr;
  logic          rd_v;
  logic [AW-1:0] rd_idx;
  logic          rd_ok;
  logic          overflow;

  logic          re;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wkey;
  logic [23:0]   wcount;
  logic          issue;
  logic          hit;
  logic          miss;
  logic          append;

  always_comb begin
    issue  = (tstate == T_SCAN) && (addr < used);
    hit    = (tstate == T_SCAN) && rd_v && (rd_key == key);
    miss   = (tstate == T_SCAN) && rd_v && !hit && (UW'(rd_idx) == used - UW'(1));
    // an empty table takes the first fragment without a scan
    append = miss || (tstate == T_IDLE && cmd.count && used == '0);

    re    = issue || (tstate == T_IDLE && cmd.read);
    raddr = issue ? addr[AW-1:0] : AW'(entry_index);

    we     = hit || (append && used < UW'(DEPTH));
    waddr  = hit ? rd_idx : used[AW-1:0];
    wkey   = (tstate == T_IDLE) ? key_in : key;
    wcount = 24'd1;
    if (hit) wcount = (rd_count == COUNT_MAX) ? rd_count : rd_count + 24'd1;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      count_mem[waddr] <= wcount;
    end
    if (re) begin
      rd_key   <= key_mem[raddr];
      rd_count <= count_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate   <= T_IDLE;
      used     <= '0;
      overflow <= 1'b0;
      rd_v     <= 1'b0;
    end else begin
      rd_v <= issue && !hit && !miss;
      if (append) begin
        if (used < UW'(DEPTH)) used <= used + UW'(1);
        else overflow <= 1'b1;
      end
      case (tstate)
        T_IDLE: begin
          if (cmd.clear) begin
            used     <= '0;
            overflow <= 1'b0;
          end else if (cmd.count && used != '0) begin
            tstate <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (hit || miss) tstate <= T_IDLE;
        end
        default: tstate <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tstate == T_IDLE && cmd.count) begin
      key  <= key_in;
      addr <= '0;
    end else if (issue) begin
      addr <= addr + UW'(1);
    end
    if (issue) rd_idx <= addr[AW-1:0];
    if (tstate == T_IDLE && cmd.read) rd_ok <= (CW'(entry_index) < CW'(used));
  end

  assign stat.busy     = (tstate == T_SCAN);
  assign stat.rd_ok    = rd_ok;
  assign stat.overflow = overflow;

endmodule
`default_nettype wire

### hdl/strided_fragment_counter.sv
`default_nettype none
// Counts fragments of a byte text in a table kept in order of first appearance.
// A push item (func 0) compares its pending fragment with the table entries up
// to the last on a miss, stops early on a match, and skips the scan with nothing
// pending: the stored fragment is compared against one table entry per cycle
// through the single read port of the table memory, while the stride phase is
// reduced by an 8-step remainder unit. A read item (func 1) puts the registered
// memory read in an output register; no further items are taken until it is
// loaded. A clear item (func 2) empties window and table; func 3 is ignored. The
// user must write configuration (fragment_length at index 0, stride_length at
// index 1) through cfg_write while no item is in progress; it is not enforced.
module strided_fragment_counter #(
  parameter int MAX_FRAGMENT_BYTES = 8,
  parameter int TABLE_DEPTH        = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  func,
  input  wire  [7:0]  text_byte,
  input  wire  [7:0]  entry_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] entry_key,
  output logic [23:0] entry_count,
  output logic        entry_valid,
  output logic [8:0]  entries_in_use,
  output logic        table_overflow
);
  import sfc_pkg::*;

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] CFG_FRAGMENT_LENGTH = 2'd0;
  localparam logic [1:0] CFG_STRIDE_LENGTH   = 2'd1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [3:0] fragment_length;
  logic [7:0] stride_length;

  logic          accept;
  logic          load_out;
  win_cmd_t      win_cmd;
  tbl_cmd_t      tbl_cmd;
  tbl_stat_t     tbl_stat;
  logic          win_busy;
  logic          pend_valid;
  logic [63:0]   pend_key;
  logic [63:0]   rd_key;
  logic [23:0]   rd_count;
  logic [UW-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_length <= 4'd4;
      stride_length   <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAGMENT_LENGTH: fragment_length <= cfg_data[3:0];
        CFG_STRIDE_LENGTH:   stride_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    accept        = in_valid && in_ready;
    win_cmd.push  = accept && func == FUNC_PUSH;
    win_cmd.clear = accept && func == FUNC_CLEAR;
    // the pending fragment is counted before the new byte enters the window
    tbl_cmd.count = win_cmd.push && pend_valid;
    tbl_cmd.read  = accept && func == FUNC_READ;
    tbl_cmd.clear = win_cmd.clear;
    load_out      = (state == S_READ) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (win_cmd.push) state <= S_PUSH;
          else if (tbl_cmd.read) state <= S_READ;
        end
        S_PUSH: begin
          if (!win_busy && !tbl_stat.busy) state <= S_IDLE;
        end
        S_READ: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      entry_key      <= tbl_stat.rd_ok ? rd_key : 64'd0;
      entry_count    <= tbl_stat.rd_ok ? rd_count : 24'd0;
      entry_valid    <= tbl_stat.rd_ok;
      entries_in_use <= 9'(used);
      table_overflow <= tbl_stat.overflow;
    end
  end

  sfc_window #(
    .MAX_BYTES (MAX_FRAGMENT_BYTES)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .cmd        (win_cmd),
    .text_byte  (text_byte),
    .frag_len   (fragment_length),
    .stride     (stride_length),
    .busy       (win_busy),
    .pend_valid (pend_valid),
    .pend_key   (pend_key)
  );

  sfc_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .cmd         (tbl_cmd),
    .key_in      (pend_key),
    .entry_index (entry_index),
    .stat        (tbl_stat),
    .rd_key      (rd_key),
    .rd_count    (rd_count),
    .used        (used)
  );

endmodule
`default_nettype wire
